FILE: hw/rtl/crlf_pkg.sv
package crlf_pkg;

    localparam int COORD_W     = 12;
    localparam int CALC_W      = 14;
    localparam int DIM_W       = 7;
    localparam int PIXEL_W     = 32;
    localparam int OP_W        = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_LINE = 3'd0;
    localparam logic [OP_W-1:0] OP_RECT = 3'd1;
    localparam logic [OP_W-1:0] OP_FILL = 3'd2;
    localparam logic [OP_W-1:0] OP_SET  = 3'd3;
    localparam logic [OP_W-1:0] OP_GET  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR    = 2'd2;

    localparam logic [DIM_W-1:0]   RST_CANVAS_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0]   RST_CANVAS_HEIGHT = 7'd64;
    localparam logic [PIXEL_W-1:0] RST_DRAW_COLOR    = 32'd0;

    localparam logic [1:0] SEG_FIRST = 2'd0;
    localparam logic [1:0] SEG_LAST  = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_DRAW,
        ST_READ,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic       in_ready;
        logic       load;
        logic       clear_we;
        logic       setup;
        logic       draw_step;
        logic       read_issue;
        logic       result_load;
        logic [1:0] seg;
    } ctrl_cmd_t;

    typedef struct packed {
        logic            clear_last;
        logic            seg_empty;
        logic            last_pixel;
        logic [OP_W-1:0] op;
    } dp_sts_t;

endpackage

FILE: hw/rtl/crlf_ctrl.sv
module crlf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_free,
    input  crlf_pkg::dp_sts_t  sts,
    output crlf_pkg::ctrl_cmd_t cmd
);
    import crlf_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] seg_reg, seg_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            seg_reg   <= SEG_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        seg_next   = seg_reg;
        cmd        = '0;
        cmd.seg    = seg_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    seg_next   = SEG_FIRST;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
                priority if (sts.op > OP_GET)
                begin
                    state_next = ST_RESP;
                end
                else if (sts.op == OP_GET)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                cmd.draw_step = !sts.seg_empty;
                if (sts.seg_empty || sts.last_pixel)
                begin
                    // outline: advance to the next edge
                    if (sts.op == OP_RECT && seg_reg != SEG_LAST)
                    begin
                        seg_next   = seg_reg + 2'd1;
                        state_next = ST_SETUP;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_READ:
            begin
                cmd.read_issue = 1'b1;
                state_next     = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_clear_completes: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == ST_CLEAR && state_reg != ST_CLEAR) |-> $past(sts.clear_last))
        else $error("clearing pass left before its last entry");

    a_multi_seg_outline_only: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_reg != SEG_FIRST) |-> (sts.op == OP_RECT))
        else $error("segment index advanced for a non-outline command");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_SETUP))
        else $error("accepted command did not enter setup");

endmodule

FILE: hw/rtl/crlf_datapath.sv
module crlf_datapath #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  crlf_pkg::ctrl_cmd_t                   cmd,
    output crlf_pkg::dp_sts_t                     sts,
    input  logic                                  cfg_we,
    input  logic [crlf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [crlf_pkg::PIXEL_W-1:0]          cfg_data,
    input  logic [crlf_pkg::OP_W-1:0]             op,
    input  logic signed [crlf_pkg::COORD_W-1:0]   coord_a_x,
    input  logic signed [crlf_pkg::COORD_W-1:0]   coord_a_y,
    input  logic signed [crlf_pkg::COORD_W-1:0]   coord_b_x,
    input  logic signed [crlf_pkg::COORD_W-1:0]   coord_b_y,
    output logic [crlf_pkg::PIXEL_W-1:0]          res_pixel,
    output logic                                  res_status
);
    import crlf_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XB    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic signed [CALC_W-1:0] MAXW  = CALC_W'(MAX_WIDTH);
    localparam logic signed [CALC_W-1:0] MAXH  = CALC_W'(MAX_HEIGHT);
    localparam logic signed [CALC_W-1:0] ZERO  = '0;
    localparam logic signed [CALC_W-1:0] ONE   = CALC_W'(1);
    localparam logic [AW-1:0]            LAST_ADDR = AW'(DEPTH - 1);

    // configuration
    logic [DIM_W-1:0]   canvas_width_reg, canvas_height_reg;
    logic [PIXEL_W-1:0] draw_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= RST_CANVAS_WIDTH;
            canvas_height_reg <= RST_CANVAS_HEIGHT;
            draw_color_reg    <= RST_DRAW_COLOR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data[DIM_W-1:0];
                CFG_DRAW_COLOR:    draw_color_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // command registers
    logic [OP_W-1:0]           op_reg;
    logic signed [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            ax_reg <= coord_a_x;
            ay_reg <= coord_a_y;
            bx_reg <= coord_b_x;
            by_reg <= coord_b_y;
        end
    end

    // effective canvas size, clamped to 1..MAX
    logic signed [CALC_W-1:0] eff_w, eff_h, w_ext, h_ext;

    always_comb
    begin
        w_ext = CALC_W'(canvas_width_reg);
        h_ext = CALC_W'(canvas_height_reg);
        priority if (canvas_width_reg == '0) eff_w = ONE;
        else if (w_ext > MAXW)                eff_w = MAXW;
        else                                  eff_w = w_ext;
        priority if (canvas_height_reg == '0) eff_h = ONE;
        else if (h_ext > MAXH)                 eff_h = MAXH;
        else                                   eff_h = h_ext;
    end

    // segment select and clipping to an inclusive box
    logic signed [CALC_W-1:0] ax, ay, bx, by;
    logic signed [CALC_W-1:0] sax, say, sbx, sby;
    logic signed [CALC_W-1:0] lo, hi, xe, ye, xl, xh, yl, yh, w_m1, h_m1;
    logic                     seg_empty;

    always_comb
    begin
        ax   = CALC_W'(ax_reg);
        ay   = CALC_W'(ay_reg);
        bx   = CALC_W'(bx_reg);
        by   = CALC_W'(by_reg);
        w_m1 = eff_w - ONE;
        h_m1 = eff_h - ONE;
        sax  = ax;
        say  = ay;
        sbx  = bx;
        sby  = by;
        if (op_reg == OP_RECT)
        begin
            unique case (cmd.seg)
                2'd0: sby = ay;
                2'd1: say = by;
                2'd2: sbx = ax;
                default: sax = bx;
            endcase
        end
        else if (op_reg == OP_SET || op_reg == OP_GET)
        begin
            sbx = ax;
            sby = ay;
        end
        lo = ZERO;
        hi = ZERO;
        xe = ax + bx;
        ye = ay + by;
        xl = ZERO;
        xh = ZERO;
        yl = ZERO;
        yh = ZERO;
        seg_empty = 1'b1;
        if (op_reg == OP_FILL)
        begin
            xl = (ax < ZERO) ? ZERO : ax;
            yl = (ay < ZERO) ? ZERO : ay;
            xh = ((xe > eff_w) ? eff_w : xe) - ONE;
            yh = ((ye > eff_h) ? eff_h : ye) - ONE;
            seg_empty = (bx <= ZERO) || (by <= ZERO) || (xl > xh) || (yl > yh);
        end
        else if (say == sby)
        begin
            lo = (sax < sbx) ? sax : sbx;
            hi = (sax < sbx) ? sbx : sax;
            xl = (lo < ZERO) ? ZERO : lo;
            xh = (hi > w_m1) ? w_m1 : hi;
            yl = say;
            yh = say;
            seg_empty = (say < ZERO) || (say > h_m1) || (xl > xh);
        end
        else if (sax == sbx)
        begin
            lo = (say < sby) ? say : sby;
            hi = (say < sby) ? sby : say;
            yl = (lo < ZERO) ? ZERO : lo;
            yh = (hi > h_m1) ? h_m1 : hi;
            xl = sax;
            xh = sax;
            seg_empty = (sax < ZERO) || (sax > w_m1) || (yl > yh);
        end
    end

    // raster walk over the clipped box
    logic [XB-1:0] cur_x_reg, x_lo_reg, x_hi_reg;
    logic [YB-1:0] cur_y_reg, y_hi_reg;
    logic          seg_empty_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            cur_x_reg     <= xl[XB-1:0];
            x_lo_reg      <= xl[XB-1:0];
            x_hi_reg      <= xh[XB-1:0];
            cur_y_reg     <= yl[YB-1:0];
            y_hi_reg      <= yh[YB-1:0];
            seg_empty_reg <= seg_empty;
        end
        else if (cmd.draw_step)
        begin
            if (cur_x_reg == x_hi_reg)
            begin
                cur_x_reg <= x_lo_reg;
                cur_y_reg <= cur_y_reg + YB'(1);
            end
            else
            begin
                cur_x_reg <= cur_x_reg + XB'(1);
            end
        end
    end

    // clearing pass counter
    logic [AW-1:0] clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
        end
        else if (cmd.clear_we)
        begin
            clear_addr_reg <= clear_addr_reg + AW'(1);
        end
    end

    // frame store
    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] mem_q_reg;
    logic [AW-1:0]      pix_addr, wr_addr;
    logic [PIXEL_W-1:0] wr_data;
    logic               mem_we;

    assign pix_addr = AW'(cur_y_reg) * AW'(MAX_WIDTH) + AW'(cur_x_reg);
    assign mem_we   = cmd.clear_we || cmd.draw_step;
    assign wr_addr  = cmd.clear_we ? clear_addr_reg : pix_addr;
    assign wr_data  = cmd.clear_we ? '0 : draw_color_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.read_issue && !seg_empty_reg)
        begin
            mem_q_reg <= mem[pix_addr];
        end
    end

    assign res_pixel  = (op_reg == OP_GET && !seg_empty_reg) ? mem_q_reg : '0;
    assign res_status = (op_reg == OP_SET || op_reg == OP_GET) && seg_empty_reg;

    assign sts.clear_last = (clear_addr_reg == LAST_ADDR);
    assign sts.seg_empty  = seg_empty_reg;
    assign sts.last_pixel = (cur_x_reg == x_hi_reg) && (cur_y_reg == y_hi_reg);
    assign sts.op         = op_reg;

    a_walk_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.draw_step |-> (!seg_empty_reg && cur_x_reg <= x_hi_reg && cur_x_reg >= x_lo_reg
                           && cur_y_reg <= y_hi_reg))
        else $error("pixel write outside the clipped box");

    a_write_in_canvas: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.draw_step |-> (CALC_W'(cur_x_reg) < eff_w && CALC_W'(cur_y_reg) < eff_h))
        else $error("pixel write outside the canvas");

endmodule

FILE: hw/rtl/clipped_rect_line_fill_top.sv
// Drawing engine over a MAX_WIDTH x MAX_HEIGHT frame store of 32-bit pixels, pixel (x,y) at
// word y*MAX_WIDTH+x. Each input beat is one command: line (horizontal or vertical span, a
// diagonal draws nothing), rectangle outline (one span per edge), rectangle fill (left, top,
// width, height), set pixel and get pixel; every command returns exactly one output beat with
// the read pixel (zero unless get) and a status bit that flags a set or get outside the canvas.
// All drawing is clipped to the canvas given by the width and height registers (zero acts as
// one, values above the maximum act as the maximum) and uses the draw color register. Timing:
// after reset the store is swept to zero one word per cycle over all MAX_WIDTH*MAX_HEIGHT words
// (4096 with the default sizes), and no command is taken until it ends. A command then passes
// through acceptance, a setup step per span (again for each outline edge), a walk writing one
// pixel per cycle (a span clipped away entirely writes nothing), then the result hand-over, which
// waits while the output register holds an untaken beat; a get pixel goes through acceptance,
// setup, a read and the hand-over. The single write port of the frame store sets this pace.
// Commands are taken one at a time; the next one is accepted while the previous result still
// waits in the output register. Configuration writes belong between commands only.
module clipped_rect_line_fill_top #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // command beat: op[2:0], coord_a_x[14:3], coord_a_y[26:15], coord_b_x[38:27],
    // coord_b_y[50:39], zero fill [55:51]
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [crlf_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // result beat: pixel_value[31:0], status[32], zero fill [39:33]
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [crlf_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // register write: 0 canvas_width, 1 canvas_height, 2 draw_color
    input  logic                                   cfg_we,
    input  logic [crlf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [crlf_pkg::PIXEL_W-1:0]           cfg_data
);
    import crlf_pkg::*;

    ctrl_cmd_t          cmd;
    dp_sts_t            sts;
    logic               out_free;
    logic [PIXEL_W-1:0] res_pixel;
    logic               res_status;

    // output register, parts the engine from the result consumer
    logic               m_valid_reg;
    logic [PIXEL_W-1:0] pixel_value_reg;
    logic               status_reg;

    // unpack the command beat
    logic [OP_W-1:0]           op;
    logic signed [COORD_W-1:0] coord_a_x, coord_a_y, coord_b_x, coord_b_y;

    assign op        = s_axis_tdata[2:0];
    assign coord_a_x = s_axis_tdata[14:3];
    assign coord_a_y = s_axis_tdata[26:15];
    assign coord_b_x = s_axis_tdata[38:27];
    assign coord_b_y = s_axis_tdata[50:39];

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = cmd.in_ready;

    crlf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    crlf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (op),
        .coord_a_x  (coord_a_x),
        .coord_a_y  (coord_a_y),
        .coord_b_x  (coord_b_x),
        .coord_b_y  (coord_b_y),
        .res_pixel  (res_pixel),
        .res_status (res_status)
    );

    // hold the result beat until taken, load a new one when the slot frees up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            pixel_value_reg <= res_pixel;
            status_reg      <= res_status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, status_reg, pixel_value_reg};

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_axis_tready) |=> !$past(cmd.result_load))
        else $error("pending result beat overwritten");

endmodule
